// ----- rtl/core/rem_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rem_pkg
// Shared widths, opcodes, scaling constants and the command and status
// structs that join the RMS meter controller and datapath.
// ----------------------------------------------------------------------------
package rem_pkg;

	localparam int OPC_W    = 2;
	localparam int SMP_W    = 16;
	localparam int IDX_W    = 8;
	localparam int LVL_W    = 13;
	localparam int FILLO_W  = 8;
	localparam int POS_W    = 8;
	localparam int SUB_EN_W = 38;
	localparam int SQ_W     = 32;
	localparam int SQR_W    = 2 * SMP_W;

	localparam int RING_POINTS_DEF    = 240;
	localparam int SUBS_PER_CHUNK_DEF = 8;

	localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// sub-block lengths at 16 kHz and 8 kHz
	localparam int LEN_HI = 200;
	localparam int LEN_LO = 100;

	// level = floor(root * 4096 / 6000) = floor(root * SCALE_M >> SCALE_SH) for root < 6000
	localparam int                 RMS_REF    = 6000;
	localparam logic [LVL_W-1:0]   FULL_SCALE = 13'd4096;
	localparam int                 SCALE_M_W  = 22;
	localparam logic [SCALE_M_W-1:0] SCALE_M  = 22'd2863312;
	localparam int                 SCALE_SH   = 22;
	localparam int                 PROD_W     = LVL_W + SCALE_M_W;

	typedef struct packed {
		logic take_item;
		logic square;
		logic accum;
		logic close_sub;
		logic store_point;
		logic start_chunk;
		logic store_level;
		logic clear;
		logic rd_start;
		logic rd_addr;
		logic rd_mem;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OPC_W-1:0] op;
		logic             pos_last;
		logic             chunk_last;
		logic             level_done;
		logic             out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/rem_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rem_if
// Valid/ready channels for meter commands and meter results.
// ----------------------------------------------------------------------------
interface rem_in_if import rem_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic signed [SMP_W-1:0] sample;
	logic [IDX_W-1:0]        point_index;

	modport source (output valid, opcode, sample, point_index, input ready);
	modport sink   (input valid, opcode, sample, point_index, output ready);
endinterface

interface rem_out_if import rem_pkg::*;;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [LVL_W-1:0]   value;
	logic [LVL_W-1:0]   chunk_level;
	logic               chunk_done;
	logic [FILLO_W-1:0] fill_count;

	modport source (output valid, kind, value, chunk_level, chunk_done, fill_count,
		input ready);
	modport sink   (input valid, kind, value, chunk_level, chunk_done, fill_count,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rem_level.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rem_level
// Iterative level unit: restoring divide of energy by count (one bit a
// cycle), digit-by-digit square root (one step a cycle), then scale and clamp.
// ----------------------------------------------------------------------------
module rem_level import rem_pkg::*; #(
	parameter int EN_W = 41,
	parameter int DV_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [EN_W-1:0]  dividend,
	input  wire logic [DV_W-1:0]  divisor,
	output logic                  done,
	output logic [LVL_W-1:0]      level
);

	localparam int CW = $clog2(EN_W);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_DIV  = 3'd1;
	localparam logic [2:0] L_SQRT = 3'd2;
	localparam logic [2:0] L_MUL  = 3'd3;
	localparam logic [2:0] L_SAT  = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DV_W-1:0]   rem_q;
	logic [EN_W-1:0]   quo_q;
	logic [DV_W-1:0]   dvs_q;
	logic [SQ_W-1:0]   x_q;
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   bit_q;
	logic [PROD_W-1:0] prod_q;
	logic              sat_q;
	logic [LVL_W-1:0]  level_q;

	logic [DV_W:0]     shifted;
	logic [DV_W:0]     diff;
	logic              ge;
	logic [SQ_W:0]     trial;
	logic              take;

	assign shifted = {rem_q, quo_q[EN_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign take    = {1'b0, x_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (cnt_q == CW'(EN_W - 1)) begin
						cnt_q   <= '0;
						state_q <= L_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				L_SQRT: begin
					if (cnt_q == CW'(SQ_W / 2 - 1)) begin
						cnt_q   <= '0;
						state_q <= L_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				L_MUL: begin
					state_q <= L_SAT;
				end
				L_SAT: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					rem_q <= '0;
					quo_q <= dividend;
					dvs_q <= divisor;
				end
			end
			L_DIV: begin
				rem_q <= ge ? diff[DV_W-1:0] : shifted[DV_W-1:0];
				quo_q <= {quo_q[EN_W-2:0], ge};
				if (cnt_q == CW'(EN_W - 1)) begin
					// final quotient bit lands in the same cycle; take the low SQ_W bits of the quotient
					x_q    <= {quo_q[SQ_W-2:0], ge};
					root_q <= '0;
					bit_q  <= SQ_W'(1) << (SQ_W - 2);
				end
			end
			L_SQRT: begin
				if (take) begin
					x_q    <= x_q - trial[SQ_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			L_MUL: begin
				prod_q <= root_q[LVL_W-1:0] * SCALE_M;
				sat_q  <= root_q >= SQ_W'(RMS_REF);
			end
			L_SAT: begin
				level_q <= sat_q ? FULL_SCALE : prod_q[PROD_W-1:SCALE_SH];
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign level = level_q;

endmodule
`default_nettype wire

// ----- rtl/core/rem_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rem_dpath
// Meter datapath: item latch, squarer, energy accumulators, point ring,
// chunk level, rate register and the output register.
// ----------------------------------------------------------------------------
module rem_dpath import rem_pkg::*; #(
	parameter int RING_POINTS    = RING_POINTS_DEF,
	parameter int SUBS_PER_CHUNK = SUBS_PER_CHUNK_DEF,
	parameter int AW             = $clog2(RING_POINTS),
	parameter int FW             = $clog2(RING_POINTS + 1),
	parameter int SP_W           = $clog2(SUBS_PER_CHUNK + 1),
	parameter int EN_W           = SUB_EN_W + $clog2(SUBS_PER_CHUNK),
	parameter int DV_W           = $clog2(LEN_HI * SUBS_PER_CHUNK + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_wdata,
	input  wire ctrl_cmd_t               cmd,
	output dp_stat_t                     stat,
	input  wire logic [OPC_W-1:0]        opcode,
	input  wire logic signed [SMP_W-1:0] sample,
	input  wire logic [IDX_W-1:0]        point_index,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         kind,
	output logic [LVL_W-1:0]             value,
	output logic [LVL_W-1:0]             chunk_level,
	output logic                         chunk_done,
	output logic [FILLO_W-1:0]           fill_count
);

	localparam int HW = (FW > IDX_W) ? FW : IDX_W;
	localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

	logic                rate_16k_q;
	logic [OPC_W-1:0]    op_q;
	logic [SMP_W-1:0]    smp_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SQR_W-1:0]    sq_s1;
	logic [SUB_EN_W-1:0] sub_en_q;
	logic [EN_W-1:0]     chunk_en_q;
	logic [POS_W-1:0]    pos_q;
	logic [SP_W-1:0]     sub_pos_q;
	logic [LVL_W-1:0]    level_reg_q;
	logic [AW-1:0]       head_q;
	logic [FW-1:0]       fill_q;
	logic [LVL_W-1:0]    point_q;
	logic                done_q;
	logic [AW-1:0]       start_s1;
	logic                hit_s1;
	logic [AW-1:0]       rd_addr_s2;
	logic [LVL_W-1:0]    rd_data_s3;
	logic [LVL_W-1:0]    ring_mem [RING_POINTS];

	logic                out_valid_q;
	logic                kind_q;
	logic [LVL_W-1:0]    value_q;
	logic [LVL_W-1:0]    chunk_level_q;
	logic                chunk_done_q;
	logic [FILLO_W-1:0]  fill_count_q;

	logic [POS_W-1:0]    len;
	logic [SMP_W-1:0]    mag;
	logic                lvl_start;
	logic [EN_W-1:0]     lvl_dividend;
	logic [DV_W-1:0]     lvl_divisor;
	logic                lvl_done;
	logic [LVL_W-1:0]    lvl_level;
	logic [FW:0]         start_raw;
	logic [FW:0]         start_wrap;
	logic [IW-1:0]       addr_raw;
	logic [IW-1:0]       addr_wrap;
	logic                is_read;

	assign len = rate_16k_q ? POS_W'(LEN_HI) : POS_W'(LEN_LO);
	assign mag = smp_q[SMP_W-1] ? (~smp_q + 1'b1) : smp_q;

	assign lvl_start    = cmd.close_sub | cmd.start_chunk;
	assign lvl_dividend = cmd.close_sub ? EN_W'(sub_en_q) : chunk_en_q;
	assign lvl_divisor  = cmd.close_sub ? DV_W'(len)
		: (rate_16k_q ? DV_W'(LEN_HI * SUBS_PER_CHUNK) : DV_W'(LEN_LO * SUBS_PER_CHUNK));

	rem_level #(
		.EN_W (EN_W),
		.DV_W (DV_W)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lvl_start),
		.dividend (lvl_dividend),
		.divisor  (lvl_divisor),
		.done     (lvl_done),
		.level    (lvl_level)
	);

	// oldest point sits fill entries behind the head
	assign start_raw  = (FW+1)'(head_q) + (FW+1)'(RING_POINTS) - (FW+1)'(fill_q);
	assign start_wrap = (start_raw >= (FW+1)'(RING_POINTS))
		? start_raw - (FW+1)'(RING_POINTS) : start_raw;
	assign addr_raw   = IW'(start_s1) + IW'(idx_q);
	assign addr_wrap  = (addr_raw >= IW'(RING_POINTS)) ? addr_raw - IW'(RING_POINTS) : addr_raw;

	assign is_read = (op_q == OP_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_16k_q  <= 1'b1;
			sub_en_q    <= '0;
			chunk_en_q  <= '0;
			pos_q       <= '0;
			sub_pos_q   <= '0;
			level_reg_q <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_16k_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				sub_en_q    <= '0;
				chunk_en_q  <= '0;
				pos_q       <= '0;
				sub_pos_q   <= '0;
				level_reg_q <= '0;
				head_q      <= '0;
				fill_q      <= '0;
			end
			if (cmd.accum) begin
				sub_en_q <= sub_en_q + SUB_EN_W'(sq_s1);
				pos_q    <= pos_q + 1'b1;
			end
			if (cmd.close_sub) begin
				chunk_en_q <= chunk_en_q + EN_W'(sub_en_q);
				sub_en_q   <= '0;
				pos_q      <= '0;
			end
			if (cmd.store_point) begin
				head_q <= (head_q == AW'(RING_POINTS - 1)) ? '0 : head_q + 1'b1;
				if (fill_q < FW'(RING_POINTS)) begin
					fill_q <= fill_q + 1'b1;
				end
				sub_pos_q <= stat.chunk_last ? '0 : sub_pos_q + 1'b1;
			end
			if (cmd.store_level) begin
				level_reg_q <= lvl_level;
				chunk_en_q  <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q  <= opcode;
			smp_q <= sample;
			idx_q <= point_index;
		end
		if (cmd.square) begin
			sq_s1 <= mag * mag;
		end
		if (cmd.store_point) begin
			point_q <= lvl_level;
			done_q  <= 1'b0;
		end
		if (cmd.store_level) begin
			done_q <= 1'b1;
		end
		if (cmd.rd_start) begin
			start_s1 <= start_wrap[AW-1:0];
			hit_s1   <= HW'(idx_q) < HW'(fill_q);
		end
		if (cmd.rd_addr) begin
			rd_addr_s2 <= addr_wrap[AW-1:0];
		end
		if (cmd.load_out) begin
			kind_q        <= is_read ? KIND_READ : KIND_POINT;
			value_q       <= is_read ? (hit_s1 ? rd_data_s3 : '0) : point_q;
			chunk_level_q <= level_reg_q;
			chunk_done_q  <= is_read ? 1'b0 : done_q;
			fill_count_q  <= FILLO_W'(fill_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_point) begin
			ring_mem[head_q] <= lvl_level;
		end
		if (cmd.rd_mem) begin
			rd_data_s3 <= ring_mem[rd_addr_s2];
		end
	end

	assign stat.op         = op_q;
	assign stat.pos_last   = (POS_W+1)'(pos_q) + 1'b1 >= (POS_W+1)'(len);
	assign stat.chunk_last = sub_pos_q == SP_W'(SUBS_PER_CHUNK - 1);
	assign stat.level_done = lvl_done;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign chunk_level = chunk_level_q;
	assign chunk_done  = chunk_done_q;
	assign fill_count  = fill_count_q;

endmodule
`default_nettype wire

// ----- rtl/core/rem_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rem_ctrl
// Meter sequencer: decodes each item and steps the datapath through
// accumulate, sub-block close, chunk close, ring read and result hand-off.
// ----------------------------------------------------------------------------
module rem_ctrl import rem_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DEC    = 4'd1;
	localparam logic [3:0] ST_SQ     = 4'd2;
	localparam logic [3:0] ST_ACC    = 4'd3;
	localparam logic [3:0] ST_CLOSE  = 4'd4;
	localparam logic [3:0] ST_WSUB   = 4'd5;
	localparam logic [3:0] ST_CHUNK  = 4'd6;
	localparam logic [3:0] ST_WCHUNK = 4'd7;
	localparam logic [3:0] ST_RD1    = 4'd8;
	localparam logic [3:0] ST_RD2    = 4'd9;
	localparam logic [3:0] ST_RD3    = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_DEC;
				end
			end
			ST_DEC: begin
				case (stat.op)
					OP_PUSH: begin
						state_d = ST_SQ;
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
					OP_READ: begin
						state_d = ST_RD1;
					end
					default: begin
						// unused opcode: drop the item
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = stat.pos_last ? ST_CLOSE : ST_IDLE;
			end
			ST_CLOSE: begin
				cmd.close_sub = 1'b1;
				state_d       = ST_WSUB;
			end
			ST_WSUB: begin
				if (stat.level_done) begin
					cmd.store_point = 1'b1;
					state_d         = stat.chunk_last ? ST_CHUNK : ST_EMIT;
				end
			end
			ST_CHUNK: begin
				cmd.start_chunk = 1'b1;
				state_d         = ST_WCHUNK;
			end
			ST_WCHUNK: begin
				if (stat.level_done) begin
					cmd.store_level = 1'b1;
					state_d         = ST_EMIT;
				end
			end
			ST_RD1: begin
				cmd.rd_start = 1'b1;
				state_d      = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_addr = 1'b1;
				state_d     = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_mem = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rms_envelope_meter.sv -----
`default_nettype none
// Push inside a sub-block: accept, decode, square, accumulate, then back to idle.
// Sub-block close adds level start, divide (EN_W = 41 by default: one quotient bit
// a cycle), square root (one root step a cycle), scale, clamp, store and emit; chunk
// close adds a level run on the chunk energy. Read: accept, decode, start and ring
// address, ring read, load out; a full output register stalls. Clear: accept, decode.
// arst_n clears meter state and ring fill, sets rate_16k to 1; ring past fill reads 0.
// ----------------------------------------------------------------------------
// rms_envelope_meter
// Block RMS level meter for 16-bit PCM with a ring of sub-block envelope points.
// ----------------------------------------------------------------------------
module rms_envelope_meter import rem_pkg::*; #(
	parameter int RING_POINTS    = RING_POINTS_DEF,
	parameter int SUBS_PER_CHUNK = SUBS_PER_CHUNK_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	rem_in_if.sink     in_ch,
	rem_out_if.source  out_ch
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      in_ready;

	rem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rem_dpath #(
		.RING_POINTS    (RING_POINTS),
		.SUBS_PER_CHUNK (SUBS_PER_CHUNK)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (in_ch.opcode),
		.sample      (in_ch.sample),
		.point_index (in_ch.point_index),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.kind        (out_ch.kind),
		.value       (out_ch.value),
		.chunk_level (out_ch.chunk_level),
		.chunk_done  (out_ch.chunk_done),
		.fill_count  (out_ch.fill_count)
	);

	assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RMS envelope meter. A table of directed items
// comes first, then random traffic in phases at both sample rates. The phases
// include rate switches inside a sub-block, a chunk close at 8 kHz, clears,
// reads around the fill count and a long output stall. Every result is checked
// field by field against an in-bench level predictor or the table's expected result.
// ----------------------------------------------------------------------------
module tb_top;
	import rem_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_CYCLES = 2 * (1 + 41 + 16 + 3) + 16;
	localparam int MAX_REPORTS  = 40;
	localparam int RING         = RING_POINTS_DEF;
	localparam int SUBS         = SUBS_PER_CHUNK_DEF;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [LVL_W-1:0]   value;
		logic [LVL_W-1:0]   chunk_level;
		logic               chunk_done;
		logic [FILLO_W-1:0] fill_count;
	} meter_result_t;

	typedef struct packed {
		logic [OPC_W-1:0]        op;
		logic signed [SMP_W-1:0] smp;
		logic [IDX_W-1:0]        idx;
		logic                    typed;
		meter_result_t           want;
	} dir_row_t;

	typedef enum int {TONE_SILENT, TONE_TINY, TONE_NOISE, TONE_FULL, TONE_RAIL,
		TONE_SQUARE} tone_e;

	localparam meter_result_t READ_EMPTY = '{KIND_READ, '0, '0, 1'b0, '0};
	localparam meter_result_t NO_RESULT  = '0;

	// empty meter reads, ignored opcode, sample extremes, clears
	localparam dir_row_t DIR_ROWS [15] = '{
		'{OP_READ,   16'sh0000, 8'h00, 1'b1, READ_EMPTY},
		'{OP_READ,   16'sh0000, 8'hFF, 1'b1, READ_EMPTY},
		'{OP_UNUSED, 16'sh8000, 8'hFF, 1'b0, NO_RESULT},
		'{OP_READ,   16'shFFFF, 8'h01, 1'b1, READ_EMPTY},
		'{OP_PUSH,   16'sh8000, 8'h00, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'sh7FFF, 8'hFF, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'sh0000, 8'h00, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'shFFFF, 8'h55, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'sh0001, 8'hAA, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'sh5A5A, 8'h00, 1'b0, NO_RESULT},
		'{OP_CLEAR,  16'shFFFF, 8'hFF, 1'b0, NO_RESULT},
		'{OP_PUSH,   16'sh8001, 8'h00, 1'b0, NO_RESULT},
		'{OP_CLEAR,  16'sh0000, 8'h00, 1'b0, NO_RESULT},
		'{OP_READ,   16'sh0000, 8'h00, 1'b1, READ_EMPTY},
		'{OP_READ,   16'sh0000, 8'h80, 1'b1, READ_EMPTY}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	rem_in_if  in_ch ();
	rem_out_if out_ch ();

	rms_envelope_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state
	logic             rate_hi;
	logic [63:0]      energy_sub;
	logic [63:0]      energy_chunk;
	int               pos_in_sub;
	int               subs_done;
	logic [LVL_W-1:0] chunk_lvl;
	logic [LVL_W-1:0] ring_pts [RING];
	int               wr_ptr;
	int               n_held;

	meter_result_t pending_results [$];

	tone_e tone_mode = TONE_SILENT;
	int    tone_amp  = 0;

	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	int hold_seq     = 0;

	int n_items = 0, n_points = 0, n_reads = 0, n_chunks = 0, n_clears = 0;
	int n_wraps = 0, n_checked = 0, err_count = 0, cycle_count = 0;

	function automatic logic [LVL_W-1:0] level_for(input logic [63:0] energy, input int count);
		logic [63:0] mean_sq, root, trial, scaled;
		int b;
		if (count == 0)
			return '0;
		mean_sq = energy / 64'(count);
		root = '0;
		for (b = 23; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= mean_sq)
				root = trial;
		end
		scaled = root * 64'(FULL_SCALE) / 64'(RMS_REF);
		return (scaled > 64'(FULL_SCALE)) ? FULL_SCALE : LVL_W'(scaled);
	endfunction

	task automatic clear_meter_state();
		energy_sub   = '0;
		energy_chunk = '0;
		pos_in_sub   = 0;
		subs_done    = 0;
		chunk_lvl    = '0;
		foreach (ring_pts[i])
			ring_pts[i] = '0;
		wr_ptr = 0;
		n_held = 0;
	endtask

	task automatic predict_meter(input logic [OPC_W-1:0] op, input logic signed [SMP_W-1:0] smp,
		input logic [IDX_W-1:0] idx, output bit has_res, output meter_result_t res);
		int          sub_len;
		logic [63:0] mag;
		logic [LVL_W-1:0] pt;
		logic        closed;
		sub_len = rate_hi ? LEN_HI : LEN_LO;
		has_res = 1'b0;
		res     = '0;
		case (op)
			OP_PUSH: begin
				mag = (smp < 0) ? 64'(-int'(smp)) : 64'(int'(smp));
				energy_sub += mag * mag;
				pos_in_sub++;
				if (pos_in_sub >= sub_len) begin
					pt = level_for(energy_sub, sub_len);
					energy_chunk += energy_sub;
					energy_sub = '0;
					pos_in_sub = 0;
					if (n_held == RING)
						n_wraps++;
					ring_pts[wr_ptr] = pt;
					wr_ptr = (wr_ptr + 1) % RING;
					if (n_held < RING)
						n_held++;
					subs_done++;
					closed = 1'b0;
					if (subs_done >= SUBS) begin
						chunk_lvl = level_for(energy_chunk, sub_len * SUBS);
						energy_chunk = '0;
						subs_done = 0;
						closed = 1'b1;
						n_chunks++;
					end
					has_res = 1'b1;
					res = '{KIND_POINT, pt, chunk_lvl, closed, FILLO_W'(n_held)};
					n_points++;
				end
			end
			OP_CLEAR: begin
				clear_meter_state();
				n_clears++;
			end
			OP_READ: begin
				pt = '0;
				if (int'(idx) < n_held)
					pt = ring_pts[(wr_ptr + RING - n_held + int'(idx)) % RING];
				has_res = 1'b1;
				res = '{KIND_READ, pt, chunk_lvl, 1'b0, FILLO_W'(n_held)};
				n_reads++;
			end
			default: ;
		endcase
	endtask

	task automatic pick_tone();
		tone_mode = tone_e'($urandom_range(0, 5));
		case (tone_mode)
			TONE_NOISE:  tone_amp = $urandom_range(0, 12000);
			TONE_RAIL:   tone_amp = $urandom_range(0, 1) ? 32767 : -32768;
			TONE_SQUARE: tone_amp = $urandom_range(0, 9000);
			default:     tone_amp = 0;
		endcase
	endtask

	function automatic logic signed [SMP_W-1:0] next_sample();
		int s;
		case (tone_mode)
			TONE_SILENT: s = 0;
			TONE_TINY:   s = int'($urandom_range(0, 16)) - 8;
			TONE_NOISE:  s = int'($urandom_range(0, 2 * tone_amp)) - tone_amp;
			TONE_FULL:   s = int'($urandom_range(0, 65535)) - 32768;
			TONE_RAIL:   s = tone_amp;
			default:     s = $urandom_range(0, 1) ? tone_amp : -tone_amp;
		endcase
		return SMP_W'(s);
	endfunction

	// lean on the edges around the fill count
	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 5))
			0:       return IDX_W'(n_held - 1);
			1:       return IDX_W'(n_held);
			2:       return '0;
			default: return IDX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic [OPC_W-1:0] op, input logic signed [SMP_W-1:0] smp,
		input logic [IDX_W-1:0] idx, input bit typed = 1'b0,
		input meter_result_t typed_want = '0);
		bit            has_res;
		meter_result_t res;
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.opcode      <= op;
		in_ch.sample      <= smp;
		in_ch.point_index <= idx;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		predict_meter(op, smp, idx, has_res, res);
		if (has_res)
			pending_results.push_back(typed ? typed_want : res);
		if (op != OP_UNUSED)
			n_items++;
	endtask

	// drop valid, wait out every pending result and the tail of a push
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic hi);
		cfg_we    <= 1'b1;
		cfg_wdata <= hi;
		@(posedge clk);
		rate_hi = hi;
		cfg_we <= 1'b0;
	endtask

	task automatic push_to_pos(input int target);
		while (pos_in_sub != target) begin
			if (pos_in_sub == 0)
				pick_tone();
			send_item(OP_PUSH, next_sample(), IDX_W'($urandom));
		end
	endtask

	task automatic run_mixed(input int n_ops, input int min_points, input bit allow_clear);
		int done_ops;
		int start_points;
		int roll;
		done_ops     = 0;
		start_points = n_points;
		while (done_ops < n_ops || n_points - start_points < min_points) begin
			roll = $urandom_range(0, 999);
			if (roll < 60) begin
				send_item(OP_READ, SMP_W'($urandom), pick_index());
				done_ops++;
			end else if (roll < 64 && allow_clear) begin
				send_item(OP_CLEAR, SMP_W'($urandom), IDX_W'($urandom));
				done_ops++;
			end else if (roll >= 64 && roll < 72) begin
				send_item(OP_UNUSED, SMP_W'($urandom), IDX_W'($urandom));
			end else begin
				if (pos_in_sub == 0)
					pick_tone();
				send_item(OP_PUSH, next_sample(), IDX_W'($urandom));
				done_ops++;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch on %s at result %0d: got %0d, expected %0d",
				what, n_checked, got, want);
	endtask

	always @(posedge clk) begin : result_check
		meter_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", int'(out_ch.value), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.kind !== want.kind)
					report_mismatch("kind", int'(out_ch.kind), int'(want.kind));
				if (out_ch.value !== want.value)
					report_mismatch("value", int'(out_ch.value), int'(want.value));
				if (out_ch.chunk_level !== want.chunk_level)
					report_mismatch("chunk_level", int'(out_ch.chunk_level),
						int'(want.chunk_level));
				if (out_ch.chunk_done !== want.chunk_done)
					report_mismatch("chunk_done", int'(out_ch.chunk_done),
						int'(want.chunk_done));
				if (out_ch.fill_count !== want.fill_count)
					report_mismatch("fill_count", int'(out_ch.fill_count),
						int'(want.fill_count));
			end
		end
	end

	initial begin : result_sink
		int hold_seen;
		out_ch.ready = 1'b0;
		hold_seen    = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				// long hold: let the meter back up into its input
				hold_seen = hold_seq;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.opcode      = OP_PUSH;
		in_ch.sample      = '0;
		in_ch.point_index = '0;
		rate_hi           = 1'b1;
		clear_meter_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_item(DIR_ROWS[i].op, DIR_ROWS[i].smp, DIR_ROWS[i].idx,
				DIR_ROWS[i].typed, DIR_ROWS[i].want);

		drain_results();
		write_rate(1'b1);
		run_mixed(150, 0, 1'b1);

		// stall the output while reads keep coming
		hold_seq <= hold_seq + 1;
		repeat (30) send_item(OP_READ, SMP_W'($urandom), pick_index());
		drain_results();

		// switch to 8 kHz with 150 samples held: next push closes the sub-block
		push_to_pos(150);
		drain_results();
		write_rate(1'b0);

		// eight points in a row always close a chunk
		run_mixed(0, SUBS, 1'b0);

		// back to 16 kHz halfway into a short sub-block
		push_to_pos(50);
		drain_results();
		write_rate(1'b1);
		run_mixed(100, 0, 1'b1);

		drain_results();
		write_rate(1'b0);
		src_idle_en = 1'b0;
		sink_idle_en <= 1'b0;
		run_mixed(100, 0, 1'b1);
		drain_results();

		$display("covered %0d items: %0d envelope points, %0d chunk closes, %0d reads, %0d clears",
			n_items, n_points, n_chunks, n_reads, n_clears);
		$display("both rates with switches inside a sub-block, %0d ring overwrites, %0d mismatches",
			n_wraps, err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
